/* hdl/cross_neighbour_sum_stencil_macros.svh */
// Assertion macros shared by the stencil RTL.
`ifndef CROSS_NEIGHBOUR_SUM_STENCIL_MACROS_SVH
`define CROSS_NEIGHBOUR_SUM_STENCIL_MACROS_SVH

// Check that cond holds at every clock edge outside reset.
`define CNS_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define CNS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/cns_pkg.sv */
`default_nettype none
package cns_pkg;

    localparam int VALUE_W        = 16;
    localparam int SUM_W          = 18;
    localparam int M_TDATA_W      = 24;
    localparam int S_TDATA_W      = 16;
    localparam int CFG_INDEX_W    = 1;
    localparam int CFG_DATA_W     = 11;
    localparam int COLS_FIELD_W   = 6;
    localparam int ROWS_FIELD_W   = 11;
    localparam int COLS_RESET     = 3;
    localparam int ROWS_RESET     = 3;
    localparam int MAX_COLS_DFLT  = 32;
    localparam int MAX_ROWS_DFLT  = 1024;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_COLS = 1'b0,
        REG_ROWS = 1'b1
    } cfg_reg_t;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic signed [SUM_W-1:0]   sum_t;

endpackage
`default_nettype wire

/* hdl/cross_neighbour_sum_stencil.sv */
//  channel   dir  handshake               payload
//  s_*       in   s_tvalid / s_tready     s_tdata: value
//  m_*       out  m_tvalid / m_tready     m_tdata: sum, m_tlast: last
//  cfg_*     in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
//  One element per cycle while s_tready is high; each element past the first
//  row yields one result from the row above, in the output register in the next cycle.
//  The final element of a matrix starts a flush pass over cols columns with s_tready low.
//  rst_n clears counters and the output valid at once; no clearing pass.
//  A low m_tready with a result waiting holds both cell chains.
//  A configuration write restarts the matrix and drops a pending result.
`default_nettype none
module cross_neighbour_sum_stencil
#(
    parameter int MAX_COLS = cns_pkg::MAX_COLS_DFLT,
    parameter int MAX_ROWS = cns_pkg::MAX_ROWS_DFLT
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [cns_pkg::S_TDATA_W-1:0]      s_tdata,   // [15:0] value
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [cns_pkg::M_TDATA_W-1:0]           m_tdata,   // [17:0] sum, rest zero
    output logic                                    m_tlast,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [cns_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [cns_pkg::CFG_DATA_W-1:0]     cfg_data
);

    `include "cross_neighbour_sum_stencil_macros.svh"

    localparam int CW  = $clog2(MAX_COLS + 1);
    localparam int IW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COLS_INIT = (cns_pkg::COLS_RESET > MAX_COLS) ? MAX_COLS
                                                                : cns_pkg::COLS_RESET;
    localparam int ROWS_INIT = (cns_pkg::ROWS_RESET > MAX_ROWS) ? MAX_ROWS
                                                                : cns_pkg::ROWS_RESET;
    localparam int COLS_FIELD_W_L = cns_pkg::COLS_FIELD_W;
    localparam int ROWS_FIELD_W_L = cns_pkg::ROWS_FIELD_W;

    logic [CW-1:0]   cols_reg;
    logic [RCW-1:0]  rows_reg;
    logic [IW-1:0]   in_col_reg;
    logic [RW-1:0]   in_row_reg;
    logic            flush_reg;
    logic [IW-1:0]   fcol_reg;
    logic            out_valid_reg;
    logic            out_last_reg;
    cns_pkg::sum_t   out_sum_reg;
    cns_pkg::value_t west_reg;

    cns_pkg::sum_t   sum_next;
    logic [CW-1:0]   cols_next;
    logic [RCW-1:0]  rows_next;
    logic [COLS_FIELD_W_L-1:0] craw;
    logic [ROWS_FIELD_W_L-1:0] rraw;

    logic            cfg_accept;
    logic            out_free;
    logic            s_accept;
    logic            advance;
    logic            emit_now;
    logic            last_col;
    logic            last_row;
    logic            flush_end;
    logic [IW-1:0]   ocol;
    logic            north_ok;
    logic            west_ok;
    logic            east_ok;
    logic [IW-1:0]   inj_idx;
    cns_pkg::value_t south;
    cns_pkg::value_t a_head0;
    cns_pkg::value_t a_head1;
    cns_pkg::value_t b_head0;
    cns_pkg::value_t b_head1;

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid & cfg_ready;
    assign out_free   = ~out_valid_reg | m_tready;
    assign s_tready   = ~flush_reg & out_free;
    assign s_accept   = s_tvalid & s_tready;
    assign advance    = s_accept | (flush_reg & out_free);
    assign emit_now   = advance & (flush_reg | (in_row_reg != '0));
    assign south      = flush_reg ? cns_pkg::value_t'('0) : cns_pkg::value_t'(s_tdata);
    assign inj_idx    = IW'(cols_reg - CW'(1));

    assign last_col  = (CW'(in_col_reg) + CW'(1)) == cols_reg;
    assign last_row  = (RCW'(in_row_reg) + RCW'(1)) == rows_reg;
    assign flush_end = (CW'(fcol_reg) + CW'(1)) == cols_reg;

    assign ocol     = flush_reg ? fcol_reg : in_col_reg;
    assign north_ok = flush_reg ? (in_row_reg != '0) : (in_row_reg > RW'(1));
    assign west_ok  = ocol != '0;
    assign east_ok  = (CW'(ocol) + CW'(1)) < cols_reg;

    assign craw = cfg_data[COLS_FIELD_W_L-1:0];
    assign rraw = cfg_data[ROWS_FIELD_W_L-1:0];

    always_comb
    begin
        sum_next = cns_pkg::sum_t'(south);
        if (north_ok)
        begin
            sum_next = sum_next + cns_pkg::sum_t'(b_head0);
        end
        if (west_ok)
        begin
            sum_next = sum_next + cns_pkg::sum_t'(west_reg);
        end
        if (east_ok)
        begin
            sum_next = sum_next + cns_pkg::sum_t'(a_head1);
        end
    end

    always_comb
    begin
        if (craw == '0)
        begin
            cols_next = CW'(1);
        end
        else if (32'(craw) > MAX_COLS)
        begin
            cols_next = CW'(MAX_COLS);
        end
        else
        begin
            cols_next = CW'(craw);
        end
        if (rraw == '0)
        begin
            rows_next = RCW'(1);
        end
        else if (32'(rraw) > MAX_ROWS)
        begin
            rows_next = RCW'(MAX_ROWS);
        end
        else
        begin
            rows_next = RCW'(rraw);
        end
    end

    cns_chain #(.DEPTH(MAX_COLS)) u_row_a
    (
        .clk      (clk),
        .en       (advance),
        .inj_idx  (inj_idx),
        .shift_in (south),
        .head0    (a_head0),
        .head1    (a_head1)
    );

    cns_chain #(.DEPTH(MAX_COLS)) u_row_b
    (
        .clk      (clk),
        .en       (advance),
        .inj_idx  (inj_idx),
        .shift_in (a_head0),
        .head0    (b_head0),
        .head1    (b_head1)
    );

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            west_reg <= a_head0;
        end
        if (emit_now)
        begin
            out_sum_reg  <= sum_next;
            out_last_reg <= flush_reg & flush_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg      <= CW'(COLS_INIT);
            rows_reg      <= RCW'(ROWS_INIT);
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            flush_reg     <= 1'b0;
            fcol_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (cfg_accept)
        begin
            unique case (cns_pkg::cfg_reg_t'(cfg_index))
                cns_pkg::REG_COLS: cols_reg <= cols_next;
                cns_pkg::REG_ROWS: rows_reg <= rows_next;
                default: ;
            endcase
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            flush_reg     <= 1'b0;
            fcol_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit_now)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (s_accept)
            begin
                if (!last_col)
                begin
                    in_col_reg <= in_col_reg + IW'(1);
                end
                else if (!last_row)
                begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + RW'(1);
                end
                else
                begin
                    in_col_reg <= '0;
                    flush_reg  <= 1'b1;
                    fcol_reg   <= '0;
                end
            end
            else if (flush_reg && out_free)
            begin
                if (flush_end)
                begin
                    flush_reg  <= 1'b0;
                    in_row_reg <= '0;
                end
                else
                begin
                    fcol_reg <= fcol_reg + IW'(1);
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = cns_pkg::M_TDATA_W'(unsigned'(out_sum_reg));
    assign m_tlast  = out_last_reg;

    `CNS_ASSERT(a_no_input_in_flush, !(flush_reg && s_tready), "input taken during flush")
    `CNS_ASSERT(a_col_in_range, CW'(in_col_reg) < cols_reg, "column counter out of range")
    `CNS_ASSERT(a_fcol_in_range, !flush_reg || (CW'(fcol_reg) < cols_reg), "flush column out of range")
    `CNS_ASSERT(a_hold_on_stall, !(out_valid_reg && !m_tready && advance), "chain moved while result stalled")
    `CNS_ASSERT_NEXT(a_last_ends_flush, advance && flush_reg && flush_end && !cfg_accept, !flush_reg && out_valid_reg && out_last_reg, "final result not marked")

endmodule
`default_nettype wire

/* hdl/cns_cell.sv */
`default_nettype none
module cns_cell
(
    input  wire logic            clk,
    input  wire logic            en,
    input  wire logic            inject,
    input  wire cns_pkg::value_t shift_in,
    input  wire cns_pkg::value_t from_next,
    output cns_pkg::value_t      value
);

    cns_pkg::value_t value_reg;
    cns_pkg::value_t value_next;

    always_comb
    begin
        value_next = inject ? shift_in : from_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule
`default_nettype wire

/* hdl/cns_chain.sv */
`default_nettype none
module cns_chain
#(
    parameter int DEPTH = cns_pkg::MAX_COLS_DFLT,
    localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  wire logic            clk,
    input  wire logic            en,
    input  wire logic [IW-1:0]   inj_idx,
    input  wire cns_pkg::value_t shift_in,
    output cns_pkg::value_t      head0,
    output cns_pkg::value_t      head1
);

    cns_pkg::value_t cell_q [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        cns_pkg::value_t nxt;
        if (i == DEPTH - 1)
        begin : g_end
            assign nxt = '0;
        end
        else
        begin : g_mid
            assign nxt = cell_q[i+1];
        end
        cns_cell u_cell
        (
            .clk       (clk),
            .en        (en),
            .inject    (inj_idx == IW'(i)),
            .shift_in  (shift_in),
            .from_next (nxt),
            .value     (cell_q[i])
        );
    end

    assign head0 = cell_q[0];

    if (DEPTH > 1)
    begin : g_head1
        assign head1 = cell_q[1];
    end
    else
    begin : g_nohead1
        assign head1 = '0;
    end

endmodule
`default_nettype wire
